>>> design/lsp_pkg.sv
// Lottery scheduler pick: shared types and constants.
// Used by the controller, the datapath, the modulo unit and the checker.
package lsp_pkg;

	localparam int RAND_W    = 32;
	localparam int IDX_W     = 6;
	localparam int TKIN_W    = 16;
	localparam int ST_W      = 2;
	localparam int TOTAL_W   = 22;
	localparam int DIV_CNT_W = $clog2(RAND_W);

	// item kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_PICK   = 1'b1;

	// entry status codes; code three is stored but never eligible
	localparam logic [ST_W-1:0] ST_IDLE    = 2'd0;
	localparam logic [ST_W-1:0] ST_READY   = 2'd1;
	localparam logic [ST_W-1:0] ST_CURRENT = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SUM,
		S_SUM_END,
		S_CHECK,
		S_MOD,
		S_SEL,
		S_SEL_END,
		S_PROMOTE,
		S_RESULT
	} lsp_state_t;

	typedef struct packed {
		logic clr_we;     // clearing pass write at sweep address
		logic upd_we;     // update transaction write
		logic sweep_rd;   // read at sweep address, advance it
		logic sel_phase;  // returned read data feeds the select walk
		logic rand_ld;    // capture random draw
		logic sum_clr;    // clear total, running sum, hit flag
		logic mod_start;  // start the modulo unit
		logic promote;    // write winner as current
		logic out_ld;     // load result register
	} lsp_cmd_t;

	typedef struct packed {
		logic last_addr;
		logic mod_done;
		logic total_zero;
		logic out_busy;
	} lsp_sts_t;

endpackage

>>> design/lottery_scheduler_pick.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, index, ticket_count, entry_status, random_value
// out       out_valid / out_ready  winner, found, ticket_total
//
// Update: written while idle, no result.
// Pick: two sweeps of the entry memory through its single read port, plus a
// 32-step remainder unit; only the first sweep when no eligible tickets.
// One item in flight at a time.
// Reset: a clearing pass zeroes the memory; in_ready is low.
// A waiting result does not block input; a pick only stalls at its end.
// Top level of the lottery scheduler; depends on lsp_pkg, lsp_ctrl, lsp_dp.
module lottery_scheduler_pick import lsp_pkg::*; #(
	parameter int ENTRIES     = 64,
	parameter int TICKET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [IDX_W-1:0]   index,
	input  logic [TKIN_W-1:0]  ticket_count,
	input  logic [ST_W-1:0]    entry_status,
	input  logic [RAND_W-1:0]  random_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   winner,
	output logic               found,
	output logic [TOTAL_W-1:0] ticket_total
);

	lsp_cmd_t cmd;
	lsp_sts_t sts;

	lsp_ctrl u_lsp_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsp_dp #(
		.ENTRIES     (ENTRIES),
		.TICKET_BITS (TICKET_BITS)
	) u_lsp_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.index        (index),
		.ticket_count (ticket_count),
		.entry_status (entry_status),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.winner       (winner),
		.found        (found),
		.ticket_total (ticket_total)
	);

endmodule

>>> design/lsp_mod.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on lsp_pkg for the draw width and step counter width.
module lsp_mod import lsp_pkg::*; #(
	parameter int DIV_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAND_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output logic [DIV_W-1:0]  rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RAND_W-1:0]    a_q;
	logic [DIV_W-1:0]     r_q;
	logic [DIV_W:0]       r_sh;
	logic [DIV_W:0]       r_nxt;

	always_comb begin
		r_sh  = {r_q, a_q[RAND_W-1]};
		r_nxt = r_sh;
		if (r_sh >= {1'b0, divisor}) begin
			r_nxt = r_sh - {1'b0, divisor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(RAND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q << 1;
			r_q <= r_nxt[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

>>> design/lsp_dp.sv
// Datapath: entry memory, sum and select walks, modulo unit, result register.
// Depends on lsp_pkg and lsp_mod; driven by lsp_ctrl through lsp_cmd_t.
module lsp_dp import lsp_pkg::*; #(
	parameter int ENTRIES     = 64,
	parameter int TICKET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsp_cmd_t           cmd,
	output lsp_sts_t           sts,
	input  logic [IDX_W-1:0]   index,
	input  logic [TKIN_W-1:0]  ticket_count,
	input  logic [ST_W-1:0]    entry_status,
	input  logic [RAND_W-1:0]  random_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   winner,
	output logic               found,
	output logic [TOTAL_W-1:0] ticket_total
);

	localparam int AW     = $clog2(ENTRIES);
	localparam int SW     = (TICKET_BITS < TKIN_W) ? TICKET_BITS : TKIN_W;
	localparam int TOT_W  = SW + AW;
	localparam int WORD_W = SW + ST_W;

	// word layout: {status, tickets}
	logic [WORD_W-1:0] mem [ENTRIES];

	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      rd_addr_s1;
	logic               rd_vld_s1;
	logic [WORD_W-1:0]  rd_word_s1;
	logic [SW-1:0]      rd_tk;
	logic [ST_W-1:0]    rd_st;
	logic               rd_elig;

	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   run_q;
	logic [TOT_W-1:0]   run_nxt;
	logic [TOT_W-1:0]   target_q;
	logic               hit_q;
	logic [AW-1:0]      win_q;
	logic [SW-1:0]      win_tk_q;
	logic [RAND_W-1:0]  rand_q;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [WORD_W-1:0]  mem_wd;
	logic               upd_ok;
	logic               last_addr;
	logic               total_zero;

	logic               mod_done;
	logic [TOT_W-1:0]   mod_rem;

	logic               out_valid_q;
	logic [IDX_W-1:0]   winner_q;
	logic               found_q;
	logic [TOTAL_W-1:0] ticket_total_q;

	assign rd_tk      = rd_word_s1[SW-1:0];
	assign rd_st      = rd_word_s1[WORD_W-1:SW];
	assign rd_elig    = (rd_st == ST_READY) || (rd_st == ST_CURRENT);
	assign run_nxt    = run_q + TOT_W'(rd_tk);
	assign last_addr  = addr_q == AW'(ENTRIES - 1);
	assign total_zero = total_q == '0;
	assign upd_ok     = 32'(index) < 32'(ENTRIES);

	lsp_mod #(
		.DIV_W(TOT_W)
	) u_lsp_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (rand_q),
		.divisor  (total_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// single write port: clear, update, promote and demote never overlap
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		priority if (cmd.clr_we) begin
			mem_we = 1'b1;
		end else if (cmd.upd_we) begin
			mem_we = upd_ok;
			mem_wa = AW'(index);
			mem_wd = {entry_status, SW'(ticket_count)};
		end else if (cmd.promote) begin
			mem_we = 1'b1;
			mem_wa = win_q;
			mem_wd = {ST_CURRENT, win_tk_q};
		end else if (cmd.sel_phase && rd_vld_s1 && rd_st == ST_CURRENT) begin
			// demote every current entry during the select walk
			mem_we = 1'b1;
			mem_wa = rd_addr_s1;
			mem_wd = {ST_READY, rd_tk};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_word_s1 <= mem[addr_q];
		rd_addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.sweep_rd;
			if (cmd.clr_we || cmd.sweep_rd) begin
				addr_q <= last_addr ? '0 : addr_q + AW'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rand_ld) begin
			rand_q <= random_value;
		end
		if (cmd.sum_clr) begin
			total_q <= '0;
			run_q   <= '0;
			hit_q   <= 1'b0;
		end else if (rd_vld_s1 && rd_elig) begin
			if (!cmd.sel_phase) begin
				total_q <= total_q + TOT_W'(rd_tk);
			end else begin
				run_q <= run_nxt;
				if (!hit_q && run_nxt >= target_q) begin
					hit_q    <= 1'b1;
					win_q    <= rd_addr_s1;
					win_tk_q <= rd_tk;
				end
			end
		end
		if (mod_done) begin
			target_q <= mod_rem + TOT_W'(1);
		end
		if (cmd.out_ld) begin
			winner_q       <= total_zero ? '0 : IDX_W'(win_q);
			found_q        <= !total_zero;
			ticket_total_q <= TOTAL_W'(total_q);
		end
	end

	assign sts.last_addr  = last_addr;
	assign sts.mod_done   = mod_done;
	assign sts.total_zero = total_zero;
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign winner       = winner_q;
	assign found        = found_q;
	assign ticket_total = ticket_total_q;

endmodule

>>> design/lsp_ctrl.sv
// Controller FSM: clearing pass, update writes, and the pick sequence.
// Depends on lsp_pkg; drives lsp_dp through lsp_cmd_t, reads lsp_sts_t.
module lsp_ctrl import lsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     kind,
	output logic     in_ready,
	input  lsp_sts_t sts,
	output lsp_cmd_t cmd
);

	lsp_state_t state_q;
	lsp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.last_addr) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_PICK) begin
						cmd.rand_ld = 1'b1;
						cmd.sum_clr = 1'b1;
						state_d     = S_SUM;
					end else begin
						cmd.upd_we = 1'b1;
					end
				end
			end
			S_SUM: begin
				cmd.sweep_rd = 1'b1;
				if (sts.last_addr) state_d = S_SUM_END;
			end
			// last entry's data is summed here
			S_SUM_END: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.total_zero) begin
					state_d = S_RESULT;
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				if (sts.mod_done) state_d = S_SEL;
			end
			S_SEL: begin
				cmd.sweep_rd  = 1'b1;
				cmd.sel_phase = 1'b1;
				if (sts.last_addr) state_d = S_SEL_END;
			end
			S_SEL_END: begin
				cmd.sel_phase = 1'b1;
				state_d       = S_PROMOTE;
			end
			S_PROMOTE: begin
				cmd.promote = 1'b1;
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

>>> design/lsp_checker.sv
// Port-level checker for lottery_scheduler_pick, attached by bind.
// Depends on lsp_pkg for field widths and kind codes.
module lsp_checker import lsp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               kind,
	input logic               out_valid,
	input logic               out_ready,
	input logic [IDX_W-1:0]   winner,
	input logic               found,
	input logic [TOTAL_W-1:0] ticket_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(winner) && $stable(found)
			&& $stable(ticket_total))
		else $error("result changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> winner == '0 && ticket_total == '0)
		else $error("empty pick with nonzero fields");

	a_pick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_PICK |=> !in_ready)
		else $error("input taken while pick in progress");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a pick in progress");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("input taken during clearing pass");

endmodule

bind lottery_scheduler_pick lsp_checker u_lsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.kind         (kind),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.winner       (winner),
	.found        (found),
	.ticket_total (ticket_total)
);

>>> dv/tb_lottery_scheduler_pick.sv
// Testbench for lottery_scheduler_pick: directed cases, a full table, random phases
// with sender gaps and receiver stalls, and a long output hold-off.
// Depends on lsp_pkg and the lottery_scheduler_pick top level.
`timescale 1ns / 100ps

module tb_lottery_scheduler_pick;
	import lsp_pkg::*;

	localparam int NUM_ENTRIES = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;
	// stored as written, never eligible
	localparam logic [ST_W-1:0] ST_RESERVED = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]   winner;
		logic               found;
		logic [TOTAL_W-1:0] total;
	} pick_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               kind;
	logic [IDX_W-1:0]   index;
	logic [TKIN_W-1:0]  ticket_count;
	logic [ST_W-1:0]    entry_status;
	logic [RAND_W-1:0]  random_value;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [IDX_W-1:0]   winner;
	logic               found;
	logic [TOTAL_W-1:0] ticket_total;

	// shadow copy of the entry table
	logic [TKIN_W-1:0]  tickets_tbl [NUM_ENTRIES];
	logic [ST_W-1:0]    status_tbl  [NUM_ENTRIES];
	pick_result_t       pick_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int mismatches     = 0;
	int n_updates      = 0;
	int n_found        = 0;
	int n_empty        = 0;

	lottery_scheduler_pick #(
		.ENTRIES(NUM_ENTRIES),
		.TICKET_BITS(TKIN_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.index(index),
		.ticket_count(ticket_count),
		.entry_status(entry_status),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.winner(winner),
		.found(found),
		.ticket_total(ticket_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pick_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sum eligible tickets, draw, walk eligible entries, then move the current mark.
	function automatic pick_result_t lottery_draw(input logic [RAND_W-1:0] rnd);
		longint unsigned sum;
		longint unsigned target;
		longint unsigned run;
		int win;
		int i;
		pick_result_t r;
		sum = 0;
		run = 0;
		win = 0;
		r = '0;
		for (i = 0; i < NUM_ENTRIES; i++)
			if (status_tbl[i] == ST_READY || status_tbl[i] == ST_CURRENT)
				sum += tickets_tbl[i];
		if (sum == 0)
			return r;
		target = (longint'(rnd) % sum) + 1;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			if (status_tbl[i] == ST_READY || status_tbl[i] == ST_CURRENT) begin
				run += tickets_tbl[i];
				if (run >= target) begin
					win = i;
					break;
				end
			end
		end
		for (i = 0; i < NUM_ENTRIES; i++)
			if (status_tbl[i] == ST_CURRENT)
				status_tbl[i] = ST_READY;
		status_tbl[win] = ST_CURRENT;
		r.winner = win[IDX_W-1:0];
		r.found  = 1'b1;
		r.total  = sum[TOTAL_W-1:0];
		return r;
	endfunction

	// One input transaction; valid is left high so a following item needs no gap.
	task automatic send_item(input logic k, input logic [IDX_W-1:0] idx,
		input logic [TKIN_W-1:0] tk, input logic [ST_W-1:0] st,
		input logic [RAND_W-1:0] rnd);
		pick_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		index        <= idx;
		ticket_count <= tk;
		entry_status <= st;
		random_value <= rnd;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		if (k == KIND_UPDATE) begin
			tickets_tbl[idx] = tk;
			status_tbl[idx]  = st;
			n_updates++;
		end else begin
			r = lottery_draw(rnd);
			pick_q.push_back(r);
			if (r.found)
				n_found++;
			else
				n_empty++;
		end
	endtask

	task automatic send_update(input logic [IDX_W-1:0] idx, input logic [TKIN_W-1:0] tk,
		input logic [ST_W-1:0] st);
		send_item(KIND_UPDATE, idx, tk, st, $urandom);
	endtask

	task automatic send_pick(input logic [RAND_W-1:0] rnd);
		send_item(KIND_PICK, IDX_W'($urandom), TKIN_W'($urandom), ST_W'($urandom), rnd);
	endtask

	task automatic run_random(input int n, input int pick_pct);
		logic [TKIN_W-1:0] tk;
		logic [ST_W-1:0]   st;
		logic [RAND_W-1:0] rnd;
		int sel;
		repeat (n) begin
			if ($urandom_range(99) < pick_pct) begin
				case ($urandom_range(9))
					0: rnd = '0;
					1: rnd = '1;
					default: rnd = $urandom;
				endcase
				send_pick(rnd);
			end else begin
				case ($urandom_range(7))
					0: tk = '0;
					1: tk = '1;
					2, 3: tk = TKIN_W'($urandom_range(1, 15));
					default: tk = TKIN_W'($urandom_range(0, 65535));
				endcase
				sel = $urandom_range(19);
				if (sel < 3)
					st = ST_IDLE;
				else if (sel < 11)
					st = ST_READY;
				else if (sel < 18)
					st = ST_CURRENT;
				else
					st = ST_RESERVED;
				send_update(IDX_W'($urandom_range(NUM_ENTRIES - 1)), tk, st);
			end
		end
	endtask

	task automatic test_directed_cases;
		send_pick('0);                          // empty table
		send_update(6'd5, 16'd0, ST_CURRENT);   // current entry with no tickets
		send_pick(32'h1234_5678);               // still nothing eligible, table untouched
		send_update(6'd0, 16'hFFFF, ST_READY);
		send_update(6'd63, 16'd1, ST_CURRENT);
		send_update(6'd10, 16'd100, ST_RESERVED);
		send_update(6'd20, 16'd7, ST_CURRENT);  // several current entries
		send_pick('0);
		send_pick('1);
		send_pick(32'h0000_FFFF);               // first ticket past entry 0
		send_pick(32'h0001_0006);
		send_update(6'd0, 16'd0, ST_IDLE);
		send_pick('0);
		send_update(6'd63, 16'hFFFF, ST_RESERVED);
		send_pick(32'h8000_0000);
		send_update(6'd20, 16'd0, ST_IDLE);
		send_pick('1);                          // only a zero-ticket ready entry left
		send_update(6'd33, 16'd1, ST_READY);
		send_pick('1);
	endtask

	task automatic test_full_table;
		int i;
		for (i = 0; i < NUM_ENTRIES; i++)
			send_update(i[IDX_W-1:0], 16'hFFFF, ST_READY);
		send_pick('0);
		send_pick('1);
		send_pick(32'd4194239);                 // last ticket of the largest total
		repeat (5)
			send_pick($urandom);
	endtask

	task automatic test_back_to_back;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(88, 40);
	endtask

	task automatic test_sender_gaps;
		send_idle_pct  = 75;
		recv_stall_pct = 0;
		run_random(88, 40);
	endtask

	task automatic test_receiver_stalls;
		send_idle_pct  = 0;
		recv_stall_pct = 75;
		run_random(88, 40);
	endtask

	task automatic test_light_idling;
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		run_random(88, 40);
	endtask

	// Output held off while input keeps coming: the block must stall its input.
	task automatic test_output_backpressure;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 3000;
		run_random(20, 60);
	endtask

	// receiver: long hold-off first, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pick_result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pick_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: winner=%0d found=%0b total=%0d",
						winner, found, ticket_total);
			end else begin
				want = pick_q.pop_front();
				if (winner !== want.winner || found !== want.found
						|| ticket_total !== want.total) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: exp w=%0d f=%0b t=%0d, got w=%0d f=%0b t=%0d",
							want.winner, want.found, want.total,
							winner, found, ticket_total);
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			tickets_tbl[i] = '0;
			status_tbl[i]  = ST_IDLE;
		end
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_UPDATE;
		index        = '0;
		ticket_count = '0;
		entry_status = ST_IDLE;
		random_value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_full_table();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_light_idling();
		test_output_backpressure();
		test_light_idling();

		@(negedge clk);
		in_valid       <= 1'b0;
		recv_stall_pct = 10;
		while (pick_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (pick_q.size() != 0) begin
			$display("%0d results never arrived", pick_q.size());
			mismatches += pick_q.size();
		end

		$display("covered %0d table writes and %0d draws (%0d with a winner, %0d on no tickets)",
			n_updates, n_found + n_empty, n_found, n_empty);
		$display("idle and stall phases plus a %0d-cycle output hold-off, %0d cycles, %0d mismatches",
			3000, cycle_count, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
